// ===== rtl/core/stq_pkg.sv =====
`timescale 1ns / 1ps

package stq_pkg;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_REMOVE  = 2'd1;
   localparam logic [1:0] KIND_PERFORM = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   typedef logic [1:0] rsp_sel_type;

   localparam rsp_sel_type RSP_ACK = 2'd0;
   localparam rsp_sel_type RSP_MID = 2'd1;
   localparam rsp_sel_type RSP_FIN = 2'd2;

   typedef struct packed {
      logic        load_item;
      logic        rd_en;
      logic        rd_prev;
      logic        wr_en;
      logic        wr_item;
      logic        wr_shift;
      logic        idx_inc;
      logic        idx_dec;
      logic        idx_from_cnt;
      logic        skip_set;
      logic        skip_from_idx;
      logic        cnt_sub_skip;
      logic        cnt_inc;
      logic        hold_load;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } stq_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       at_end;
      logic       idx_zero;
      logic       rd_match;
      logic       rd_due;
      logic       skip_nz;
      logic       full_after;
      logic       hold_valid;
      logic       out_free;
   } stq_status_type;

endpackage

// ===== rtl/core/stq_ctrl.sv =====
`timescale 1ns / 1ps

module stq_ctrl
   import stq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_kind,
   output logic           req_stall,
   input  stq_status_type status,
   output stq_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_UL_RD  = 4'd1;
   localparam logic [3:0] ST_UL_EV  = 4'd2;
   localparam logic [3:0] ST_UL_END = 4'd3;
   localparam logic [3:0] ST_INS_RD = 4'd4;
   localparam logic [3:0] ST_INS_EV = 4'd5;
   localparam logic [3:0] ST_ACK    = 4'd6;
   localparam logic [3:0] ST_PF_RD  = 4'd7;
   localparam logic [3:0] ST_PF_EV  = 4'd8;
   localparam logic [3:0] ST_PF_FIN = 4'd9;
   localparam logic [3:0] ST_SH_RD  = 4'd10;
   localparam logic [3:0] ST_SH_EV  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               unique case (req_kind)
                  KIND_ADD, KIND_REMOVE: state_in = ST_UL_RD;
                  KIND_PERFORM:          state_in = ST_PF_RD;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_UL_RD: begin
            if (status.at_end) begin
               state_in = ST_UL_END;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_UL_EV;
            end
         end
         ST_UL_EV: begin
            if (!status.skip_nz && status.rd_match) begin
               cmd.skip_set = 1'b1;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_shift = 1'b1;
            end
            cmd.idx_inc = 1'b1;
            state_in    = ST_UL_RD;
         end
         ST_UL_END: begin
            cmd.cnt_sub_skip = 1'b1;
            cmd.idx_from_cnt = 1'b1;
            if (status.kind == KIND_ADD && !status.full_after) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_INS_RD: begin
            if (status.idx_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_item = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_ACK;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in    = ST_INS_EV;
            end
         end
         ST_INS_EV: begin
            cmd.wr_en = 1'b1;
            if (!status.rd_due) begin
               cmd.idx_dec = 1'b1;
               state_in    = ST_INS_RD;
            end else begin
               cmd.wr_item = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_ACK;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_ACK;
               state_in     = ST_IDLE;
            end
         end
         ST_PF_RD: begin
            if (status.at_end) begin
               state_in = ST_PF_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_PF_EV;
            end
         end
         ST_PF_EV: begin
            if (status.rd_due) begin
               if (!status.hold_valid || status.out_free) begin
                  cmd.rsp_load  = status.hold_valid;
                  cmd.rsp_sel   = RSP_MID;
                  cmd.hold_load = 1'b1;
                  cmd.idx_inc   = 1'b1;
                  state_in      = ST_PF_RD;
               end
            end else begin
               state_in = ST_PF_FIN;
            end
         end
         ST_PF_FIN: begin
            if (status.out_free) begin
               cmd.rsp_load      = 1'b1;
               cmd.rsp_sel       = RSP_FIN;
               cmd.skip_from_idx = 1'b1;
               state_in          = status.hold_valid ? ST_SH_RD : ST_IDLE;
            end
         end
         ST_SH_RD: begin
            if (status.at_end) begin
               cmd.cnt_sub_skip = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SH_EV;
            end
         end
         ST_SH_EV: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_SH_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/stq_datapath.sv =====
`timescale 1ns / 1ps

module stq_datapath
   import stq_pkg::*;
#(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  stq_cmd_type    cmd,
   output stq_status_type status,
   input  logic [1:0]     req_kind,
   input  logic [3:0]     req_task_id,
   input  logic [31:0]    req_time_stamp,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output logic [3:0]     rsp_due_task,
   output logic           rsp_fired,
   output logic           rsp_was_present,
   output logic           rsp_last
);

   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam int AW = $clog2(NUM_TASKS);

   logic [3:0]           slot_task_ff     [NUM_TASKS];
   logic [TIME_BITS-1:0] slot_deadline_ff [NUM_TASKS];

   logic [1:0]           kind_ff;
   logic [3:0]           item_id_ff;
   logic [TIME_BITS-1:0] item_time_ff;
   logic [3:0]           rd_task_ff;
   logic [TIME_BITS-1:0] rd_deadline_ff;
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        idx_in;
   logic [CW-1:0]        skip_ff;
   logic [CW-1:0]        skip_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [3:0]           hold_task_ff;
   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [3:0]           rsp_task_ff;
   logic                 rsp_fired_ff;
   logic                 rsp_present_ff;
   logic                 rsp_last_ff;

   logic [CW-1:0]        idx_prev;
   logic [CW-1:0]        shift_pos;
   logic [CW-1:0]        count_left;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [3:0]           wr_task;
   logic [TIME_BITS-1:0] wr_deadline;

   assign idx_prev   = idx_ff - CW'(1);
   assign shift_pos  = idx_ff - skip_ff;
   assign count_left = count_ff - skip_ff;
   assign rd_addr    = cmd.rd_prev ? idx_prev[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr    = cmd.wr_shift ? shift_pos[AW-1:0] : idx_ff[AW-1:0];
   assign wr_task     = cmd.wr_item ? item_id_ff : rd_task_ff;
   assign wr_deadline = cmd.wr_item ? item_time_ff : rd_deadline_ff;

   always_comb begin
      status.kind       = kind_ff;
      status.at_end     = (idx_ff == count_ff);
      status.idx_zero   = (idx_ff == '0);
      status.rd_match   = (rd_task_ff == item_id_ff);
      status.rd_due     = (rd_deadline_ff <= item_time_ff);
      status.skip_nz    = (skip_ff != '0);
      status.full_after = (count_left == CW'(NUM_TASKS));
      status.hold_valid = hold_valid_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_task_ff[wr_addr]     <= wr_task;
         slot_deadline_ff[wr_addr] <= wr_deadline;
      end
      if (cmd.rd_en) begin
         rd_task_ff     <= slot_task_ff[rd_addr];
         rd_deadline_ff <= slot_deadline_ff[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.load_item) begin
         idx_in = '0;
      end else if (cmd.idx_from_cnt) begin
         idx_in = count_left;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end

      skip_in = skip_ff;
      priority if (cmd.load_item) begin
         skip_in = '0;
      end else if (cmd.skip_set) begin
         skip_in = CW'(1);
      end else if (cmd.skip_from_idx) begin
         skip_in = idx_ff;
      end

      count_in = count_ff;
      priority if (cmd.cnt_sub_skip) begin
         count_in = count_left;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end

      hold_valid_in = hold_valid_ff;
      priority if (cmd.load_item) begin
         hold_valid_in = 1'b0;
      end else if (cmd.hold_load) begin
         hold_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         skip_ff       <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         skip_ff       <= skip_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff      <= req_kind;
         item_id_ff   <= req_task_id;
         item_time_ff <= TIME_BITS'(req_time_stamp);
      end
      if (cmd.hold_load) begin
         hold_task_ff <= rd_task_ff;
      end
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            RSP_ACK: begin
               rsp_task_ff    <= item_id_ff;
               rsp_fired_ff   <= 1'b0;
               rsp_present_ff <= (skip_ff != '0);
               rsp_last_ff    <= 1'b1;
            end
            RSP_MID: begin
               rsp_task_ff    <= hold_task_ff;
               rsp_fired_ff   <= 1'b1;
               rsp_present_ff <= 1'b0;
               rsp_last_ff    <= 1'b0;
            end
            RSP_FIN: begin
               rsp_task_ff    <= hold_valid_ff ? hold_task_ff : 4'd0;
               rsp_fired_ff   <= hold_valid_ff;
               rsp_present_ff <= 1'b0;
               rsp_last_ff    <= 1'b1;
            end
            default: begin
               rsp_task_ff    <= 4'd0;
               rsp_fired_ff   <= 1'b0;
               rsp_present_ff <= 1'b0;
               rsp_last_ff    <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_due_task    = rsp_task_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/core/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   kind, task_id, time_stamp
// rsp_      out        rsp_valid/rsp_stall   due_task, fired, was_present, last
//
// Each slot visited takes a read state and an evaluate state: one slot memory port, registered read.
// Reset clears the controller, entry count, index, skip count, hold and output valid flags; slot memory is not cleared.
// rsp_stall holds the output word; work goes on until the next word needs the register.

module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_task_id,
   input  logic [31:0] req_time_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_due_task,
   output logic        rsp_fired,
   output logic        rsp_was_present,
   output logic        rsp_last
);

   stq_cmd_type    cmd;
   stq_status_type status;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stq_datapath #(
      .NUM_TASKS (NUM_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_task_id     (req_task_id),
      .req_time_stamp  (req_time_stamp),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_due_task    (rsp_due_task),
      .rsp_fired       (rsp_fired),
      .rsp_was_present (rsp_was_present),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind != KIND_UNUSED) |=> req_stall)
      else $error("block idle right after accepting a word");

   no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> req_stall)
      else $error("slot write while idle");

   load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("output word overwritten while stalled");
`endif

endmodule

// ===== test/tb_sorted_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
   import stq_pkg::*;

   localparam int SLOTS          = 16;
   localparam int PHASE_ITEMS    = 81;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  task_id;
      logic [31:0] time_stamp;
      int          snd_pct;
      int          rsp_pct;
      bit          wait_drain;
      bit          hold_rsp;
   } timer_cmd_type;

   typedef struct {
      logic [3:0] due_task;
      logic       fired;
      logic       was_present;
      logic       last;
   } timer_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_ADD;
   logic [3:0]  req_task_id = 4'd0;
   logic [31:0] req_time_stamp = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_due_task;
   logic        rsp_fired;
   logic        rsp_was_present;
   logic        rsp_last;

   timer_cmd_type    cmd_backlog[$];
   timer_report_type reports_due[$];

   logic [3:0]  tbl_task[SLOTS];
   logic [31:0] tbl_deadline[SLOTS];
   int          tbl_count = 0;

   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int fired_seen = 0;
   int empty_performs = 0;
   int rsp_idle_pct = 0;
   int hold_asks = 0;
   int hold_done = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   int          gen_snd_pct = 0;
   int          gen_rsp_pct = 0;
   bit          gen_wait = 1'b0;
   bit          gen_hold = 1'b0;
   logic [31:0] sim_now = 32'd0;

   sorted_timer_queue dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_task_id(req_task_id),
      .req_time_stamp(req_time_stamp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_due_task(rsp_due_task),
      .rsp_fired(rsp_fired),
      .rsp_was_present(rsp_was_present),
      .rsp_last(rsp_last)
   );

   always #10 clock = ~clock;

   function automatic void tbl_drop(int pos);
      for (int i = pos; i + 1 < tbl_count; i++) begin
         tbl_task[i] = tbl_task[i + 1];
         tbl_deadline[i] = tbl_deadline[i + 1];
      end
      if (tbl_count > 0) tbl_count--;
   endfunction

   function automatic bit tbl_unlink(logic [3:0] id);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_task[i] == id) begin
            tbl_drop(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void tbl_insert(logic [3:0] id, logic [31:0] when);
      int pos = 0;
      if (tbl_count >= SLOTS) return;
      while (pos < tbl_count && tbl_deadline[pos] <= when) pos++;
      for (int i = tbl_count; i > pos; i--) begin
         tbl_task[i] = tbl_task[i - 1];
         tbl_deadline[i] = tbl_deadline[i - 1];
      end
      tbl_task[pos] = id;
      tbl_deadline[pos] = when;
      tbl_count++;
   endfunction

   function automatic void timer_table_apply(logic [1:0] kind, logic [3:0] id,
                                             logic [31:0] ts);
      timer_report_type rep;
      logic [3:0]       expired[$];
      bit               present;
      case (kind)
         KIND_ADD: begin
            present = tbl_unlink(id);
            tbl_insert(id, ts);
            rep = '{id, 1'b0, present, 1'b1};
            reports_due.push_back(rep);
         end
         KIND_REMOVE: begin
            present = tbl_unlink(id);
            rep = '{id, 1'b0, present, 1'b1};
            reports_due.push_back(rep);
         end
         KIND_PERFORM: begin
            // drain due entries in deadline order
            while (tbl_count > 0 && expired.size() < SLOTS && tbl_deadline[0] <= ts) begin
               expired.push_back(tbl_task[0]);
               tbl_drop(0);
            end
            if (expired.size() == 0) begin
               rep = '{4'd0, 1'b0, 1'b0, 1'b1};
               reports_due.push_back(rep);
            end
            for (int i = 0; i < expired.size(); i++) begin
               rep = '{expired[i], 1'b1, 1'b0, i == expired.size() - 1};
               reports_due.push_back(rep);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_cmd(logic [1:0] kind, logic [3:0] id, logic [31:0] ts);
      timer_cmd_type c;
      c = '{kind, id, ts, gen_snd_pct, gen_rsp_pct, gen_wait, gen_hold};
      cmd_backlog.push_back(c);
      gen_wait = 1'b0;
      gen_hold = 1'b0;
   endfunction

   function automatic void add_random_cmd();
      int          r;
      int          pick;
      logic [1:0]  kind;
      logic [31:0] ts;
      r = $urandom_range(99);
      pick = $urandom_range(19);
      ts = $urandom();
      if (r < 5) kind = KIND_UNUSED;
      else if (r < 50) kind = KIND_ADD;
      else if (r < 70) kind = KIND_REMOVE;
      else kind = KIND_PERFORM;
      if (kind == KIND_ADD && pick > 2) begin
         ts = sim_now + $urandom_range(300);
      end else if (kind == KIND_PERFORM) begin
         if (pick == 0) ts = 32'hFFFF_FFFF;
         else if (pick > 1) begin
            sim_now = sim_now + $urandom_range(120);
            ts = sim_now;
         end
      end
      add_cmd(kind, 4'($urandom_range(15)), ts);
   endfunction

   function automatic void check_field(string name, logic [3:0] exp_val, logic [3:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
      end
   endfunction

   always @(posedge clock) begin
      timer_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            timer_table_apply(req_kind, req_task_id, req_time_stamp);
            words_in++;
         end
         if (!req_valid || !req_stall) begin
            if (cmd_backlog.size() > 0
                && (!cmd_backlog[0].wait_drain || reports_due.size() == 0)
                && $urandom_range(99) >= cmd_backlog[0].snd_pct) begin
               c = cmd_backlog.pop_front();
               req_valid <= 1'b1;
               req_kind <= c.kind;
               req_task_id <= c.task_id;
               req_time_stamp <= c.time_stamp;
               rsp_idle_pct <= c.rsp_pct;
               if (c.hold_rsp) hold_asks <= hold_asks + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (hold_left > 0) hold_left <= hold_left - 1;
         rsp_stall <= hold_left > 1 || $urandom_range(99) < rsp_idle_pct;
      end
   end

   always @(posedge clock) begin
      timer_report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (rsp_fired === 1'b1) fired_seen++;
         if (reports_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, due_task %0h fired %0b was_present %0b last %0b",
                     $time, rsp_due_task, rsp_fired, rsp_was_present, rsp_last);
         end else begin
            e = reports_due.pop_front();
            if (!e.fired && e.last && e.due_task == 4'd0 && !e.was_present) empty_performs++;
            check_field("due_task", e.due_task, rsp_due_task);
            check_field("fired", 4'(e.fired), 4'(rsp_fired));
            check_field("was_present", 4'(e.was_present), 4'(rsp_was_present));
            check_field("last", 4'(e.last), 4'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                     idle_cycles, reports_due.size());
            $display("tb_sorted_timer_queue failed");
            $finish;
         end
      end
   end

   initial begin
      int snd_tbl[5];
      int rsp_tbl[5];
      snd_tbl = '{0, 84, 0, 20, 0};
      rsp_tbl = '{0, 0, 84, 20, 0};

      add_cmd(KIND_ADD, 4'd0, 32'd0);
      add_cmd(KIND_ADD, 4'd15, 32'hFFFF_FFFF);
      add_cmd(KIND_ADD, 4'd1, 32'd100);
      add_cmd(KIND_ADD, 4'd2, 32'd100);
      add_cmd(KIND_ADD, 4'd3, 32'd100);
      add_cmd(KIND_ADD, 4'd1, 32'd100);
      for (int i = 4; i < 15; i++) add_cmd(KIND_ADD, 4'(i), 32'(i * 37));
      add_cmd(KIND_ADD, 4'd7, 32'd5);
      add_cmd(KIND_UNUSED, 4'd5, 32'd0);
      add_cmd(KIND_REMOVE, 4'd3, 32'hFFFF_FFFF);
      add_cmd(KIND_REMOVE, 4'd3, 32'd0);
      add_cmd(KIND_PERFORM, 4'd0, 32'd0);
      add_cmd(KIND_PERFORM, 4'd9, 32'd0);
      add_cmd(KIND_PERFORM, 4'd15, 32'hFFFF_FFFF);
      add_cmd(KIND_PERFORM, 4'd0, 32'hFFFF_FFFF);

      for (int p = 0; p < 5; p++) begin
         gen_snd_pct = snd_tbl[p];
         gen_rsp_pct = rsp_tbl[p];
         gen_wait = 1'b1;
         gen_hold = (p == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) add_random_cmd();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_valid || reports_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (reports_due.size() != 0) begin
         errors++;
         $display("%0t: %0d expected words never arrived", $time, reports_due.size());
      end
      $display("Sent %0d command words (add, remove, perform, unused kind), checked %0d replies:",
               words_in, words_out);
      $display("%0d expiries, %0d performs with nothing due, %0d errors", fired_seen,
               empty_performs, errors);
      if (errors == 0) begin
         $display("tb_sorted_timer_queue passed");
      end else begin
         $display("tb_sorted_timer_queue failed");
      end
      $finish;
   end

endmodule
